// ===== hdl/window_conv2d_valid_core_macros.svh =====
// assertion macros for the window filter core
`ifndef WINDOW_CONV2D_VALID_CORE_MACROS_SVH
`define WINDOW_CONV2D_VALID_CORE_MACROS_SVH

// same-cycle implication
`define WCV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcv assertion failed");

// next-cycle implication
`define WCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcv assertion failed");

`endif

// ===== hdl/wcv_pkg.sv =====
// shared constants and control types of the window filter core
package wcv_pkg;

    localparam int unsigned MAX_WIDTH_DEF      = 1024;
    localparam int unsigned MAX_KERNEL_DEF     = 5;
    localparam int unsigned SAMPLE_BITS_DEF    = 16;
    localparam int unsigned COEF_FRAC_BITS_DEF = 14;

    localparam int unsigned COEF_BITS     = 16;
    localparam int unsigned OUT_BITS      = 22;
    localparam int unsigned ROW_BITS      = 16;
    localparam int unsigned OCOL_BITS     = 10;
    localparam int unsigned IMG_W_BITS    = 11;
    localparam int unsigned KSIZE_BITS    = 3;
    localparam int unsigned KIDX_BITS     = 3;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_WIDTH  = 3'd3;

    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic shift_en;
        logic take_col;
        logic take_right;
        logic coef_we;
        logic mul_en;
        logic active;
    } t_tap_ctrl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_line_ctrl;

endpackage

// ===== hdl/window_conv2d_valid_core.sv =====
// window_conv2d_valid_core: valid-mode 2d window filter, line cells feed a tap cell array
// pipeline from pixel transaction to result valid: line read, window, multiply,
//   row sum, total sum, output register
// throughput: one transaction per cycle unless stalled; same-column write/read forwarded
// reset: clears valids, counters, coefficients and sizes to defaults; line memories untouched
`include "window_conv2d_valid_core_macros.svh"

module window_conv2d_valid_core #(
    parameter int unsigned MAX_WIDTH      = wcv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_KERNEL     = wcv_pkg::MAX_KERNEL_DEF,
    parameter int unsigned SAMPLE_BITS    = wcv_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned COEF_FRAC_BITS = wcv_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [wcv_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [wcv_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic [wcv_pkg::KIDX_BITS-1:0]          i_coef_row,
    input  logic [wcv_pkg::KIDX_BITS-1:0]          i_coef_col,
    input  logic signed [wcv_pkg::COEF_BITS-1:0]   i_coef_value,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [wcv_pkg::OUT_BITS-1:0]    o_out_value,
    output logic [wcv_pkg::ROW_BITS-1:0]           o_out_row,
    output logic [wcv_pkg::OCOL_BITS-1:0]          o_out_col,
    output logic                                   o_frame_last
);

    localparam int unsigned CW      = $clog2(MAX_WIDTH);
    localparam int unsigned CC      = CW + 1;
    localparam int unsigned WB      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned KB      = $clog2(MAX_KERNEL + 1);
    localparam int unsigned DI_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int unsigned RB      = wcv_pkg::ROW_BITS;
    localparam int unsigned PROD_W  = SAMPLE_BITS + wcv_pkg::COEF_BITS;
    // at most MAX_KERNEL**2 terms, 25 at the default kernel of 5, well under 2**8
    localparam int unsigned SUM_W   = PROD_W + 8;
    localparam int unsigned OB      = wcv_pkg::OUT_BITS;
    localparam int unsigned W_RST   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int unsigned K_RST   = (MAX_KERNEL < 3) ? MAX_KERNEL : 3;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (OB - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (OB - 1)));

    typedef struct packed {
        logic                                emit;
        logic [RB-1:0]                       orow;
        logic [wcv_pkg::OCOL_BITS-1:0]       ocol;
        logic                                last;
    } t_meta;

    // size registers and counters
    logic [WB-1:0] r_w_eff;
    logic [RB-1:0] r_h_eff;
    logic [KB-1:0] r_kh_eff;
    logic [KB-1:0] r_kw_eff;
    logic [CW-1:0] r_col;
    logic [RB-1:0] r_row;

    logic          w_en;
    logic          w_cfg_acc;
    logic          w_cfg_hit;
    logic          w_in_acc;
    logic          w_pix_acc;
    logic          w_col_last;
    logic          w_row_last;
    t_meta         n_meta;

    logic [WB-1:0]                          n_w_eff;
    logic [RB-1:0]                          n_h_eff;
    logic [KB-1:0]                          n_k_eff;
    logic [wcv_pkg::IMG_W_BITS-1:0]         w_cfg_w;
    logic [wcv_pkg::KSIZE_BITS-1:0]         w_cfg_k;

    // pipeline
    logic                                   r_s1_vld;
    logic                                   r_s1_pix;
    t_meta                                  r_s1_meta;
    logic signed [SAMPLE_BITS-1:0]          r_s1_sample;
    logic [CW-1:0]                          r_s1_col;
    logic [wcv_pkg::KIDX_BITS-1:0]          r_s1_crow;
    logic [wcv_pkg::KIDX_BITS-1:0]          r_s1_ccol;
    logic signed [wcv_pkg::COEF_BITS-1:0]   r_s1_coef;

    logic                                   r_s2_vld;
    logic                                   r_s2_pix;
    t_meta                                  r_s2_meta;
    logic [wcv_pkg::KIDX_BITS-1:0]          r_s2_crow;
    logic [wcv_pkg::KIDX_BITS-1:0]          r_s2_ccol;
    logic signed [wcv_pkg::COEF_BITS-1:0]   r_s2_coef;

    logic                                   r_s3_vld;
    t_meta                                  r_s3_meta;
    logic                                   r_s4_vld;
    t_meta                                  r_s4_meta;
    logic signed [SUM_W-1:0]                r_rsum [MAX_KERNEL];
    logic signed [SUM_W-1:0]                n_rsum [MAX_KERNEL];
    logic                                   r_s5_vld;
    t_meta                                  r_s5_meta;
    logic signed [SUM_W-1:0]                r_total;
    logic signed [SUM_W-1:0]                n_total;
    logic signed [SUM_W-1:0]                w_shift;
    logic signed [SUM_W-1:0]                w_sat;

    logic                                   r_out_valid;
    logic signed [OB-1:0]                   r_out_value;
    t_meta                                  r_out_meta;

    logic signed [SAMPLE_BITS-1:0] w_depth [MAX_KERNEL];
    logic signed [SAMPLE_BITS-1:0] w_samp  [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0]      w_prod  [MAX_KERNEL][MAX_KERNEL];
    logic                          w_win_shift;
    logic                          w_mul_en;
    logic                          w_coef_we;
    wcv_pkg::t_line_ctrl           w_line_ctrl;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_pix_acc   = w_in_acc && (i_req_type == wcv_pkg::REQ_PIXEL);

    // configuration decode with size clamping
    assign w_cfg_w = i_cfg_data[wcv_pkg::IMG_W_BITS-1:0];
    assign w_cfg_k = i_cfg_data[wcv_pkg::KSIZE_BITS-1:0];

    always_comb begin
        if (w_cfg_w == '0) begin
            n_w_eff = WB'(1);
        end else if (32'(w_cfg_w) > MAX_WIDTH) begin
            n_w_eff = WB'(MAX_WIDTH);
        end else begin
            n_w_eff = WB'(w_cfg_w);
        end
        n_h_eff = (i_cfg_data[RB-1:0] == '0) ? RB'(1) : i_cfg_data[RB-1:0];
        if (w_cfg_k == '0) begin
            n_k_eff = KB'(1);
        end else if (32'(w_cfg_k) > MAX_KERNEL) begin
            n_k_eff = KB'(MAX_KERNEL);
        end else begin
            n_k_eff = KB'(w_cfg_k);
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            wcv_pkg::REG_IMAGE_WIDTH,
            wcv_pkg::REG_IMAGE_HEIGHT,
            wcv_pkg::REG_KERNEL_HEIGHT,
            wcv_pkg::REG_KERNEL_WIDTH: w_cfg_hit = w_cfg_acc;
            default:                   w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff  <= WB'(W_RST);
            r_h_eff  <= RB'(1024);
            r_kh_eff <= KB'(K_RST);
            r_kw_eff <= KB'(K_RST);
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                wcv_pkg::REG_IMAGE_WIDTH:   r_w_eff  <= n_w_eff;
                wcv_pkg::REG_IMAGE_HEIGHT:  r_h_eff  <= n_h_eff;
                wcv_pkg::REG_KERNEL_HEIGHT: r_kh_eff <= n_k_eff;
                wcv_pkg::REG_KERNEL_WIDTH:  r_kw_eff <= n_k_eff;
                default: ;
            endcase
        end
    end

    // raster position and result tags
    assign w_col_last = (CC'(r_col) + CC'(1)) == CC'(r_w_eff);
    assign w_row_last = ({1'b0, r_row} + (RB + 1)'(1)) == {1'b0, r_h_eff};

    always_comb begin
        n_meta.emit = (({1'b0, r_row} + (RB + 1)'(1)) >= (RB + 1)'(r_kh_eff))
                   && ((CC'(r_col) + CC'(1)) >= CC'(r_kw_eff));
        n_meta.orow = r_row + RB'(1) - RB'(r_kh_eff);
        n_meta.ocol = wcv_pkg::OCOL_BITS'(CC'(r_col) + CC'(1) - CC'(r_kw_eff));
        n_meta.last = w_row_last && w_col_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_pix_acc) begin
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_s5_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_vld    <= w_in_acc;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld && r_s2_pix && r_s2_meta.emit;
            r_s4_vld    <= r_s3_vld;
            r_s5_vld    <= r_s4_vld;
            r_out_valid <= r_s5_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pix    <= i_req_type == wcv_pkg::REQ_PIXEL;
            r_s1_meta   <= n_meta;
            r_s1_sample <= i_sample;
            r_s1_col    <= r_col;
            r_s1_crow   <= i_coef_row;
            r_s1_ccol   <= i_coef_col;
            r_s1_coef   <= i_coef_value;
            r_s2_pix    <= r_s1_pix;
            r_s2_meta   <= r_s1_meta;
            r_s2_crow   <= r_s1_crow;
            r_s2_ccol   <= r_s1_ccol;
            r_s2_coef   <= r_s1_coef;
            r_s3_meta   <= r_s2_meta;
            r_s4_meta   <= r_s3_meta;
            r_s5_meta   <= r_s4_meta;
            r_total     <= n_total;
            r_out_value <= OB'(w_sat);
            r_out_meta  <= r_s5_meta;
            for (int i = 0; i < MAX_KERNEL; i++) begin
                r_rsum[i] <= n_rsum[i];
            end
        end
    end

    // line cells: depth 0 is the incoming sample, depth d is the row d lines back
    assign w_line_ctrl.rd_en = w_en;
    assign w_line_ctrl.wr_en = w_en && r_s1_vld && r_s1_pix;
    assign w_depth[0]        = r_s1_sample;

    genvar gk;
    generate
        for (gk = 1; gk < MAX_KERNEL; gk++) begin : g_line
            wcv_line_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .MAX_WIDTH   (MAX_WIDTH)
            ) u_line (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_line_ctrl),
                .i_rd_addr   (r_col),
                .i_wr_addr   (r_s1_col),
                .i_wr_sample (w_depth[gk-1]),
                .o_rd_sample (w_depth[gk])
            );
        end
    endgenerate

    // tap cell array
    assign w_win_shift = w_en && r_s1_vld && r_s1_pix;
    assign w_mul_en    = w_en && r_s2_vld && r_s2_pix && r_s2_meta.emit;
    assign w_coef_we   = w_en && r_s2_vld && !r_s2_pix;

    genvar gi, gj;
    generate
        for (gi = 0; gi < MAX_KERNEL; gi++) begin : g_row
            logic                          w_row_act;
            logic [KB-1:0]                 w_sel;
            logic signed [SAMPLE_BITS-1:0] w_col_in;

            assign w_row_act = r_kh_eff > KB'(gi);
            assign w_sel     = r_kh_eff - KB'(1) - KB'(gi);
            assign w_col_in  = w_row_act ? w_depth[w_sel[DI_BITS-1:0]] : '0;

            for (gj = 0; gj < MAX_KERNEL; gj++) begin : g_col
                wcv_pkg::t_tap_ctrl            w_ctrl;
                logic signed [SAMPLE_BITS-1:0] w_right;

                if (gj + 1 < MAX_KERNEL) begin : g_mid
                    assign w_right = w_samp[gi][gj+1];
                end else begin : g_end
                    assign w_right = '0;
                end

                assign w_ctrl.shift_en   = w_win_shift && w_row_act;
                assign w_ctrl.take_col   = r_kw_eff == KB'(gj + 1);
                assign w_ctrl.take_right = r_kw_eff > KB'(gj + 1);
                assign w_ctrl.coef_we    = w_coef_we && (32'(r_s2_crow) == 32'(gi))
                                        && (32'(r_s2_ccol) == 32'(gj));
                assign w_ctrl.mul_en     = w_mul_en;
                assign w_ctrl.active     = w_row_act && (r_kw_eff > KB'(gj));

                wcv_tap_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_tap (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_ctrl         (w_ctrl),
                    .i_col_sample   (w_col_in),
                    .i_right_sample (w_right),
                    .i_coef_value   (r_s2_coef),
                    .o_sample       (w_samp[gi][gj]),
                    .o_prod         (w_prod[gi][gj])
                );
            end
        end
    endgenerate

    // adder stages, shift and saturation
    always_comb begin
        for (int i = 0; i < MAX_KERNEL; i++) begin
            n_rsum[i] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                n_rsum[i] = n_rsum[i] + SUM_W'(w_prod[i][j]);
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            n_total = n_total + r_rsum[i];
        end
    end

    assign w_shift = r_total >>> COEF_FRAC_BITS;

    always_comb begin
        priority if (w_shift > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_shift;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_row    = r_out_meta.orow;
    assign o_out_col    = r_out_meta.ocol;
    assign o_frame_last = r_out_meta.last;

    `WCV_ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_in_ready)
    `WCV_ASSERT_IMPLY(a_col_in_range, i_clk, i_rst_n, 1'b1, CC'(r_col) < CC'(r_w_eff))
    `WCV_ASSERT_IMPLY(a_row_in_range, i_clk, i_rst_n, 1'b1, r_row < r_h_eff)
    `WCV_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, w_cfg_hit, (r_col == '0) && (r_row == '0))

endmodule

// ===== hdl/wcv_ram.sv =====
// generic single-write, registered-read ram
module wcv_ram #(
    parameter int unsigned WIDTH = wcv_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned DEPTH = wcv_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/wcv_line_cell.sv =====
// one line delay cell: a row of samples with same-column forwarding
module wcv_line_cell #(
    parameter int unsigned SAMPLE_BITS = wcv_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned MAX_WIDTH   = wcv_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wcv_pkg::t_line_ctrl                i_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]       i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]       i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]      i_wr_sample,
    output logic signed [SAMPLE_BITS-1:0]      o_rd_sample
);

    logic                   r_fwd;
    logic [SAMPLE_BITS-1:0] r_fwd_sample;
    logic [SAMPLE_BITS-1:0] w_ram_q;

    wcv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_sample),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_ram_q)
    );

    // write and read of the same column in one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_ctrl.rd_en) begin
            r_fwd <= i_ctrl.wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_fwd_sample <= i_wr_sample;
        end
    end

    assign o_rd_sample = r_fwd ? $signed(r_fwd_sample) : $signed(w_ram_q);

endmodule

// ===== hdl/wcv_tap_cell.sv =====
// one window tap: sample register, coefficient and registered product
module wcv_tap_cell #(
    parameter int unsigned SAMPLE_BITS = wcv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  wcv_pkg::t_tap_ctrl                            i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]                 i_col_sample,
    input  logic signed [SAMPLE_BITS-1:0]                 i_right_sample,
    input  logic signed [wcv_pkg::COEF_BITS-1:0]          i_coef_value,
    output logic signed [SAMPLE_BITS-1:0]                 o_sample,
    output logic signed [SAMPLE_BITS+wcv_pkg::COEF_BITS-1:0] o_prod
);

    localparam int unsigned PROD_W = SAMPLE_BITS + wcv_pkg::COEF_BITS;

    logic signed [SAMPLE_BITS-1:0]        r_sample;
    logic signed [wcv_pkg::COEF_BITS-1:0] r_coef;
    logic signed [PROD_W-1:0]             r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_ctrl.coef_we) begin
            r_coef <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            if (i_ctrl.take_col) begin
                r_sample <= i_col_sample;
            end else if (i_ctrl.take_right) begin
                r_sample <= i_right_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_ctrl.active ? PROD_W'(r_sample * r_coef) : '0;
        end
    end

    assign o_sample = r_sample;
    assign o_prod   = r_prod;

endmodule
